// ===== rtl/multi_waveform_phase_oscillator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Oscillator assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_CORE_ASSERT_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Consequent checked in the same cycle as the antecedent.
`define MWPO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("oscillator assertion failed");
// Consequent checked in the cycle after the antecedent.
`define MWPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("oscillator assertion failed");
`else
`define MWPO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MWPO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/mwpo_pkg.sv =====
// ----------------------------------------------------------------------------
// Oscillator package
// Shared constants, register codes, waveform codes and the sine table builder.
// ----------------------------------------------------------------------------
package mwpo_pkg;

    localparam int DEF_PHASE_BITS     = 32;
    localparam int DEF_SINE_ADDR_BITS = 10;
    localparam int DEF_SAMPLE_BITS    = 16;

    localparam int PHASE_MOD_W  = 32;
    localparam int PHASE_STEP_W = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE = 2'd1;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave_shape;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine magnitude for index k, evaluated at elaboration only.
    // Horner Taylor series through x^11 in Q30, every product truncated,
    // then rounded half up to frac_bits and saturated to the top code.
    function automatic logic [63:0] sine_quarter(input int unsigned k,
                                                  input int unsigned addr_bits,
                                                  input int unsigned frac_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] max_pos;
        x       = (64'(k) * HALF_PI_Q30) >> (addr_bits - 2);
        x2      = (x * x) >> 30;
        term    = Q30_ONE;
        term    = Q30_ONE - (((x2 * term) >> 30) / 64'd110);
        term    = Q30_ONE - (((x2 * term) >> 30) / 64'd72);
        term    = Q30_ONE - (((x2 * term) >> 30) / 64'd42);
        term    = Q30_ONE - (((x2 * term) >> 30) / 64'd20);
        term    = Q30_ONE - (((x2 * term) >> 30) / 64'd6);
        s       = (x * term) >> 30;
        s       = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        max_pos = (64'd1 << frac_bits) - 64'd1;
        return (s > max_pos) ? max_pos : s;
    endfunction

endpackage

// ===== rtl/mwpo_in_if.sv =====
// ----------------------------------------------------------------------------
// Oscillator input channel
// Valid/ready channel that carries the per-sample phase offset.
// ----------------------------------------------------------------------------
interface mwpo_in_if;
    import mwpo_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [PHASE_MOD_W-1:0] phase_mod;

    modport source (output valid, output phase_mod, input ready);
    modport sink   (input valid, input phase_mod, output ready);
endinterface

// ===== rtl/mwpo_out_if.sv =====
// ----------------------------------------------------------------------------
// Oscillator output channel
// Valid/ready channel that carries one waveform sample.
// ----------------------------------------------------------------------------
interface mwpo_out_if #(
    parameter int SAMPLE_BITS = mwpo_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/mwpo_phase_acc.sv =====
// ----------------------------------------------------------------------------
// Phase accumulator stage
// Adds the aligned offset and step to the phase on every input transfer.
// ----------------------------------------------------------------------------
module mwpo_phase_acc #(
    parameter int PHASE_BITS = mwpo_pkg::DEF_PHASE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [mwpo_pkg::PHASE_MOD_W-1:0] i_phase_mod,
    output logic                                  o_ready,
    input  logic        [mwpo_pkg::PHASE_STEP_W-1:0] i_phase_step,
    output logic                                  o_valid,
    output logic        [PHASE_BITS-1:0]          o_phase,
    input  logic                                  i_ready
);
    import mwpo_pkg::*;

    logic                  r_valid;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] w_mod_inc;
    logic [PHASE_BITS-1:0] w_step_inc;

    // Align the 32-bit turn fractions to the accumulator width.
    if (PHASE_BITS > 32) begin : g_wide
        assign w_mod_inc  = {i_phase_mod, {(PHASE_BITS-32){1'b0}}};
        assign w_step_inc = {i_phase_step, {(PHASE_BITS-32){1'b0}}};
    end else if (PHASE_BITS == 32) begin : g_equal
        assign w_mod_inc  = i_phase_mod;
        assign w_step_inc = i_phase_step;
    end else begin : g_narrow
        assign w_mod_inc  = i_phase_mod[PHASE_MOD_W-1 -: PHASE_BITS];
        assign w_step_inc = i_phase_step[PHASE_STEP_W-1 -: PHASE_BITS];
    end

    assign n_phase = r_phase + w_mod_inc + w_step_inc;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (o_ready && i_valid) begin
                r_phase <= n_phase;
            end
        end
    end
endmodule

// ===== rtl/mwpo_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant magnitude table with a registered read port.
// ----------------------------------------------------------------------------
module mwpo_sine_rom #(
    parameter int SINE_ADDR_BITS = mwpo_pkg::DEF_SINE_ADDR_BITS,
    parameter int SAMPLE_BITS    = mwpo_pkg::DEF_SAMPLE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [SINE_ADDR_BITS-2:0] i_addr,
    output logic [SAMPLE_BITS-2:0]    o_mag
);
    import mwpo_pkg::*;

    localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);

    logic [SAMPLE_BITS-2:0] w_rom [0:QUARTER];
    logic [SAMPLE_BITS-2:0] r_mag;

    // The table holds one quarter plus the end point, so the peak is stored.
    for (genvar g = 0; g <= QUARTER; g++) begin : g_entry
        localparam logic [63:0] MAG = sine_quarter(g, SINE_ADDR_BITS, SAMPLE_BITS - 1);
        assign w_rom[g] = MAG[SAMPLE_BITS-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= w_rom[i_addr];
        end
    end

    assign o_mag = r_mag;
endmodule

// ===== rtl/mwpo_wave_gen.sv =====
// ----------------------------------------------------------------------------
// Waveform generator
// Turns a phase into a sine, saw, triangle or square sample over two stages.
// ----------------------------------------------------------------------------
module mwpo_wave_gen #(
    parameter int PHASE_BITS     = mwpo_pkg::DEF_PHASE_BITS,
    parameter int SINE_ADDR_BITS = mwpo_pkg::DEF_SINE_ADDR_BITS,
    parameter int SAMPLE_BITS    = mwpo_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mwpo_pkg::t_wave_shape         i_wave_shape,
    input  logic                          i_valid,
    input  logic [PHASE_BITS-1:0]         i_phase,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    input  logic                          i_ready
);
    import mwpo_pkg::*;

    localparam int EXT_BITS = SAMPLE_BITS + 1;
    localparam int QUARTER  = 1 << (SINE_ADDR_BITS - 2);

    localparam logic signed [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIN_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS:0]          HALF    = (SAMPLE_BITS+1)'(1) << (SAMPLE_BITS-1);
    localparam logic [SAMPLE_BITS:0]          FULL2   = (SAMPLE_BITS+1)'(1) << SAMPLE_BITS;
    localparam logic [PHASE_BITS-1:0]         PH_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

    logic [EXT_BITS-1:0]         w_ext;
    logic [SINE_ADDR_BITS-1:0]   w_idx;
    logic [SINE_ADDR_BITS-3:0]   w_j;
    logic [SINE_ADDR_BITS-2:0]   w_k;
    logic [SAMPLE_BITS-1:0]      w_saw_top;
    logic [SAMPLE_BITS:0]        w_saw_diff;
    logic [SAMPLE_BITS:0]        w_tri_top;
    logic [SAMPLE_BITS:0]        w_tri_abs;
    logic [SAMPLE_BITS:0]        w_tri_diff;
    logic signed [SAMPLE_BITS-1:0] w_alt;
    logic [SAMPLE_BITS-2:0]      w_mag;
    logic signed [SAMPLE_BITS-1:0] w_sine_pos;
    logic                        w_b_ready;
    logic                        w_c_ready;
    logic                        w_b_load;

    logic                          r_b_valid;
    logic                          r_b_is_sine;
    logic                          r_b_neg;
    logic signed [SAMPLE_BITS-1:0] r_b_alt;
    logic                          r_c_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    // Top phase bits, padded with zeros when the phase is narrower.
    if (PHASE_BITS >= EXT_BITS) begin : g_ext_cut
        assign w_ext = i_phase[PHASE_BITS-1 -: EXT_BITS];
    end else begin : g_ext_pad
        assign w_ext = {i_phase, {(EXT_BITS-PHASE_BITS){1'b0}}};
    end

    // Sine address: fold the phase onto the first quarter.
    assign w_idx = i_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign w_j   = w_idx[SINE_ADDR_BITS-3:0];
    assign w_k   = w_idx[SINE_ADDR_BITS-2]
                 ? ((SINE_ADDR_BITS-1)'(QUARTER) - {1'b0, w_j})
                 : {1'b0, w_j};

    // Saw is one minus twice the phase; zero phase gives full scale.
    assign w_saw_top  = w_ext[EXT_BITS-1 -: SAMPLE_BITS];
    assign w_saw_diff = HALF - {1'b0, w_saw_top};

    // Triangle is the distance from half a turn, shifted down by one half.
    assign w_tri_top  = w_ext[EXT_BITS-1 -: SAMPLE_BITS+1];
    assign w_tri_abs  = w_tri_top[SAMPLE_BITS] ? {1'b0, w_tri_top[SAMPLE_BITS-1:0]}
                                               : (FULL2 - w_tri_top);
    assign w_tri_diff = w_tri_abs - HALF;

    always_comb begin
        case (i_wave_shape)
            WAVE_SAW:    w_alt = (w_saw_top == '0) ? MAX_POS : w_saw_diff[SAMPLE_BITS-1:0];
            WAVE_TRI:    w_alt = (w_tri_abs == FULL2) ? MAX_POS
                                                      : w_tri_diff[SAMPLE_BITS-1:0];
            WAVE_SQUARE: w_alt = (!i_phase[PHASE_BITS-1] || i_phase == PH_HALF)
                               ? MAX_POS : MIN_NEG;
            default:     w_alt = '0;
        endcase
    end

    assign w_c_ready = !r_c_valid || i_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign w_b_load  = i_valid && w_b_ready;
    assign o_ready   = w_b_ready;

    mwpo_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_b_load),
        .i_addr (w_k),
        .o_mag  (w_mag)
    );

    assign w_sine_pos = {1'b0, w_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_b_ready) begin
                r_b_valid <= i_valid;
            end
            if (w_c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_load) begin
            r_b_is_sine <= (i_wave_shape == WAVE_SINE);
            r_b_neg     <= w_idx[SINE_ADDR_BITS-1];
            r_b_alt     <= w_alt;
        end
        if (w_c_ready && r_b_valid) begin
            if (r_b_is_sine) begin
                r_sample <= r_b_neg ? -w_sine_pos : w_sine_pos;
            end else begin
                r_sample <= r_b_alt;
            end
        end
    end

    assign o_valid  = r_c_valid;
    assign o_sample = r_sample;
endmodule

// ===== rtl/multi_waveform_phase_oscillator_core.sv =====
// An input transfer passes through the phase register, the sine table read
// register and the output register before its sample appears.
// Throughput: one sample per cycle while the output is ready; with the output
// held, the three-stage valid/ready pipeline holds three samples and then stalls its input.
// Reset clears the phase, phase_step, wave_shape and all stage valids at once;
// the sine table is constant and needs no clearing.
// ----------------------------------------------------------------------------
// Multi-waveform phase oscillator core
// Phase accumulator with sine, saw, triangle and square outputs in Q1.15.
// ----------------------------------------------------------------------------
`include "multi_waveform_phase_oscillator_core_assert.svh"

module multi_waveform_phase_oscillator_core #(
    parameter int PHASE_BITS     = mwpo_pkg::DEF_PHASE_BITS,
    parameter int SINE_ADDR_BITS = mwpo_pkg::DEF_SINE_ADDR_BITS,
    parameter int SAMPLE_BITS    = mwpo_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mwpo_in_if.sink                           i_in,
    mwpo_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [mwpo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mwpo_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import mwpo_pkg::*;

    logic [PHASE_STEP_W-1:0] r_phase_step;
    t_wave_shape             r_wave_shape;

    logic                  w_in_ready;
    logic                  w_acc_valid;
    logic [PHASE_BITS-1:0] w_phase;
    logic                  w_gen_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_wave_shape <= WAVE_SINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PHASE_STEP: r_phase_step <= i_cfg_wdata[PHASE_STEP_W-1:0];
                CFG_WAVE_SHAPE: r_wave_shape <= t_wave_shape'(i_cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    mwpo_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_phase_mod  (i_in.phase_mod),
        .o_ready      (w_in_ready),
        .i_phase_step (r_phase_step),
        .o_valid      (w_acc_valid),
        .o_phase      (w_phase),
        .i_ready      (w_gen_ready)
    );

    assign i_in.ready = w_in_ready;

    mwpo_wave_gen #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wave_shape (r_wave_shape),
        .i_valid      (w_acc_valid),
        .i_phase      (w_phase),
        .o_ready      (w_gen_ready),
        .o_valid      (o_out.valid),
        .o_sample     (o_out.sample_out),
        .i_ready      (o_out.ready)
    );

    // The phase only moves on an input transfer.
    `MWPO_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !(i_in.valid && w_in_ready), $stable(w_phase))
    // An input transfer always leaves a live item in the phase stage.
    `MWPO_ASSERT_NEXT(a_acc_fill, i_clk, i_rst_n, i_in.valid && w_in_ready, w_acc_valid)
    // The input stalls only when every stage is full and the output is held.
    `MWPO_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, !w_in_ready, w_acc_valid && o_out.valid && !o_out.ready)
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Oscillator core testbench
// Drives phase offsets and register writes into the oscillator core, predicts
// every sample from its own model of the phase accumulator and the four
// waveforms, and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import mwpo_pkg::*;

    localparam int SMP_W     = 16;
    localparam int FRAC_W    = SMP_W - 1;
    localparam int ADDR_W    = 10;
    localparam int QTR_SIZE  = 1 << (ADDR_W - 2);
    localparam int MAX_CODE  = (1 << FRAC_W) - 1;
    localparam int MIN_CODE  = -(1 << FRAC_W);

    localparam longint unsigned Q30_UNIT    = 64'd1 << 30;
    localparam longint unsigned QTR_TURN_Q30 = 64'd1686629713;

    // Indexes past the end of the register map; the core must ignore them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_ITEMS  = 1100;

    class osc_scoreboard;
        logic [31:0]             phase_acc;
        logic [31:0]             step_reg;
        t_wave_shape             shape_reg;
        logic signed [SMP_W-1:0] expected_samples[$];
        int                      errors;

        function new();
            phase_acc = '0;
            step_reg  = '0;
            shape_reg = WAVE_SINE;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PHASE_STEP: step_reg = data[31:0];
                CFG_WAVE_SHAPE: shape_reg = t_wave_shape'(data[1:0]);
                default: ;
            endcase
        endfunction

        // Quarter-wave sine magnitude: Taylor series in Q30, truncated products.
        function int sine_magnitude(int unsigned k);
            longint unsigned taylor_div[5] = '{110, 72, 42, 20, 6};
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned s;
            x    = (longint'(k) * QTR_TURN_Q30) >> (ADDR_W - 2);
            x2   = (x * x) >> 30;
            term = Q30_UNIT;
            for (int i = 0; i < 5; i++)
                term = Q30_UNIT - ((x2 * term) >> 30) / taylor_div[i];
            s = (x * term) >> 30;
            s = (s + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W);
            return (s > MAX_CODE) ? MAX_CODE : int'(s);
        endfunction

        function logic signed [SMP_W-1:0] shape_sample(logic [31:0] p);
            int          v;
            int          mag;
            int unsigned k;
            logic [1:0]  quad;
            logic [7:0]  j;
            case (shape_reg)
                WAVE_SINE: begin
                    quad = p[31:30];
                    j    = p[29:22];
                    k    = quad[0] ? QTR_SIZE - int'(j) : int'(j);
                    mag  = sine_magnitude(k);
                    v    = quad[1] ? -mag : mag;
                end
                WAVE_SAW: begin
                    v = (1 << FRAC_W) - int'(p[31:16]);
                    if (v > MAX_CODE) v = MAX_CODE;
                end
                WAVE_TRI: begin
                    v = int'(p[31:15]) - (2 << FRAC_W);
                    if (v < 0) v = -v;
                    v = v - (1 << FRAC_W);
                    if (v > MAX_CODE) v = MAX_CODE;
                end
                default: begin
                    v = (p <= 32'h8000_0000) ? MAX_CODE : MIN_CODE;
                end
            endcase
            return v[SMP_W-1:0];
        endfunction

        function void note_transfer(logic [31:0] phase_mod);
            phase_acc = phase_acc + phase_mod + step_reg;
            expected_samples.push_back(shape_sample(phase_acc));
        endfunction

        function void check_sample(logic signed [SMP_W-1:0] got);
            logic signed [SMP_W-1:0] want;
            if (expected_samples.size() == 0) begin
                $error("sample_out: no sample expected, got %0d", got);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want) begin
                $error("sample_out: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    mwpo_in_if                          in_ch ();
    mwpo_out_if #(.SAMPLE_BITS(SMP_W))  out_ch ();

    osc_scoreboard board;
    bit            calm;
    bit            hold_req  = 1'b0;
    bit            hold_done = 1'b0;
    int            hold_left = 0;

    multi_waveform_phase_oscillator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 9);
    endfunction

    // Output side: check each transfer, then choose the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            board.check_sample(out_ch.sample_out);
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !take_break();
        end
    end

    task automatic offer_mod(input logic [31:0] phase_mod);
        while (take_break()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.phase_mod <= phase_mod;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        board.note_transfer(phase_mod);
    endtask

    // Offset chosen so that the accumulator lands exactly on the target.
    task automatic goto_phase(input logic [31:0] target);
        offer_mod(target - board.phase_acc - board.step_reg);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_mod();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] random_step();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            5:       return $urandom();
            default: return 32'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        int len;

        board    = new();
        calm     = 1'b0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_PHASE_STEP;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.phase_mod <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sine from reset: zero, quarter-turn peak, half, three quarters, extremes.
        offer_mod(32'd0);
        offer_mod(32'h4000_0000);
        offer_mod(32'h4000_0000);
        offer_mod(32'h4000_0000);
        offer_mod(32'h7FFF_FFFF);
        offer_mod(32'h8000_0000);
        offer_mod(32'hFFFF_FFFF);

        // Saw: positive full scale at zero phase, bottom just below a full turn.
        settle();
        write_reg(CFG_WAVE_SHAPE, 32'(WAVE_SAW));
        goto_phase(32'h0000_0000);
        goto_phase(32'hFFFF_FFFF);
        goto_phase(32'h8000_0000);

        // Triangle: saturated top at zero phase, minimum at half a turn.
        settle();
        write_reg(CFG_WAVE_SHAPE, 32'(WAVE_TRI));
        goto_phase(32'h0000_0000);
        goto_phase(32'h4000_0000);
        goto_phase(32'h8000_0000);
        goto_phase(32'hC000_0000);

        // Square: exactly half a turn is still high, one step beyond is low.
        settle();
        write_reg(CFG_WAVE_SHAPE, 32'(WAVE_SQUARE));
        goto_phase(32'h8000_0000);
        goto_phase(32'h8000_0001);
        goto_phase(32'h0000_0000);
        goto_phase(32'hFFFF_FFFF);

        // Writes past the map and register bits above the width are dropped.
        settle();
        write_reg(CFG_SPARE_2, $urandom());
        write_reg(CFG_SPARE_3, $urandom());
        write_reg(CFG_WAVE_SHAPE, 32'hFFFF_FFFC | 32'(WAVE_SAW));
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        offer_mod(32'h8000_0000);
        offer_mod(32'h7FFF_FFFF);
        offer_mod($urandom());

        settle();
        write_reg(CFG_PHASE_STEP, 32'h8000_0000);
        write_reg(CFG_WAVE_SHAPE, 32'(WAVE_SQUARE));
        offer_mod(32'd0);
        offer_mod(32'd0);
        offer_mod(32'd0);

        sent  = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            calm = 1'b0;
            write_reg(CFG_PHASE_STEP, random_step());
            write_reg(CFG_WAVE_SHAPE, 32'($urandom_range(0, 3)) | ($urandom() & 32'hFFFF_FFFC));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom());
            calm = (burst == 3);
            // The receiver holds off for a long while; the sender keeps offering.
            if (burst == 5)
                hold_req = 1'b1;
            len = $urandom_range(40, 140);
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            repeat (len) begin
                offer_mod(random_mod());
                sent++;
            end
            burst++;
        end
        calm = 1'b0;
        settle();
        repeat (8) @(posedge i_clk);

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
